>>> hw/rtl/ffcg_pkg.sv
// Shared types and constants for the flame flicker color generator.
`timescale 1ns / 1ps

package ffcg_pkg;

   localparam int LEVEL_W = 8;
   localparam int DUR_W   = LEVEL_W + 1;
   localparam int CFG_W   = 8;
   localparam int TICK_W  = 32;
   localparam int DIV_W   = 40;
   localparam int QUO_W   = 32;
   localparam int CNT_W   = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX  = '1;
   localparam logic [TICK_W-1:0]  RECIP_NUM  = '1;

   localparam int GREEN_MUL = 33;
   localparam int GREEN_DIV = 120;

   localparam logic [CFG_W-1:0] TIME_BASE_RST  = 8'd10;
   localparam logic [CFG_W-1:0] TIME_SPAN_RST  = 8'd45;
   localparam logic [CFG_W-1:0] LEVEL_BASE_RST = 8'd25;
   localparam logic [CFG_W-1:0] LEVEL_SPAN_RST = 8'd75;

   // highest quotient bit produced for each kind of division
   localparam logic [CNT_W-1:0] Q_RECIP = 5'd31;
   localparam logic [CNT_W-1:0] Q_EXTRA = 5'd7;
   localparam logic [CNT_W-1:0] Q_LEVEL = 5'd7;
   localparam logic [CNT_W-1:0] Q_GREEN = 5'd11;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIME_BASE,
      CSR_TIME_SPAN,
      CSR_LEVEL_BASE,
      CSR_LEVEL_SPAN
   } csr_index_type;

   typedef enum logic [2:0] {
      DIV_RECIP_T,
      DIV_EXTRA_T,
      DIV_RECIP_L,
      DIV_EXTRA_L,
      DIV_LEVEL,
      DIV_GREEN
   } div_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_COMMIT,
      ST_SPAN,
      ST_PROD,
      ST_GREEN_PREP,
      ST_RESULT
   } ctrl_state_type;

   typedef struct packed {
      logic       load_in;
      logic       div_start;
      logic       div_capture;
      div_op_type div_op;
      logic       commit_rt;
      logic       calc_span;
      logic       calc_prod;
      logic       calc_green;
      logic       load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic active;
      logic retarget_due;
      logic dur_zero;
      logic div_busy;
      logic rsp_free;
   } dp_stat_type;

endpackage

>>> hw/rtl/flame_flicker_color_generator.sv
// Top level of the flame flicker color generator.
//
//   channel  direction  transaction contents
//   req_*    in         tdata: now_tick, rand_time, rand_level; tuser: active
//   rsp_*    out        tdata: red, green; tuser: retargeted
//   csr_*    in         write of one 8-bit register, no read-back
//
// A request is taken only in the idle state, so each transaction reaches its result
// before the next is taken; a retarget first adds four divisions on the shared
// divider, and an inactive transaction goes straight to its result.
// Reset is synchronous; it restores the register defaults and clears the state.
// A pending result waits in the output register while the next request is taken;
// a stalled rsp_tready holds the following result back, and the input with it.
`timescale 1ns / 1ps

module flame_flicker_color_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // now_tick[31:0], rand_time[63:32], rand_level[95:64]
   input  logic        req_tuser,   // active
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // red[7:0], green[15:8]
   output logic        rsp_tuser,   // retargeted
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import ffcg_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   ffcg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ffcg_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> hw/rtl/ffcg_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ffcg_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [ffcg_pkg::DIV_W-1:0] dividend,
   input  logic [ffcg_pkg::DIV_W-1:0] divisor,
   input  logic [ffcg_pkg::CNT_W-1:0] qbits,
   output logic                      busy,
   output logic [ffcg_pkg::QUO_W-1:0] quotient
);
   import ffcg_pkg::*;

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dsh_ff, dsh_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             ge;

   always_comb begin
      ge      = (rem_ff >= dsh_ff);
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = dividend;
         dsh_in  = divisor << qbits;
         quo_in  = '0;
         cnt_in  = qbits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? (rem_ff - dsh_ff) : rem_ff;
         dsh_in  = dsh_ff >> 1;
         quo_in  = {quo_ff[QUO_W-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

>>> hw/rtl/ffcg_dp.sv
// Datapath: configuration, flame state, operand selection and result register.
`timescale 1ns / 1ps

module ffcg_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  ffcg_pkg::ctrl_cmd_type        cmd,
   output ffcg_pkg::dp_stat_type         stat,
   input  logic [95:0]                   req_tdata,
   input  logic                          req_tuser,
   input  logic                          csr_we,
   input  logic [ffcg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ffcg_pkg::CFG_W-1:0]    csr_wdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,
   output logic                          rsp_tuser
);
   import ffcg_pkg::*;

   localparam int PROD_W = LEVEL_W + DUR_W;
   localparam int BASE_W = DUR_W + 7;
   localparam int GNUM_W = LEVEL_W + BASE_W - 1;
   localparam int GDIV_W = DUR_W + 7;

   logic [CFG_W-1:0]   time_base_ff, time_span_ff, level_base_ff, level_span_ff;
   logic               active_ff;
   logic [TICK_W-1:0]  now_ff, rt_ff, rl_ff;
   logic [LEVEL_W-1:0] flame_ff, start_level_ff, goal_level_ff;
   logic [TICK_W-1:0]  start_time_ff, goal_time_ff;
   logic               retarget_ff;
   logic [QUO_W-1:0]   recip_ff;
   logic [CFG_W-1:0]   extra_t_ff, extra_l_ff;
   logic [DUR_W-1:0]   dur_ff, dur_in, e_ff, e_in;
   logic [PROD_W-1:0]  pa_ff, pb_ff;
   logic [LEVEL_W-1:0] level_ff, green_ff;
   logic [GNUM_W-1:0]  gnum_ff, gnum_in;
   logic [GDIV_W-1:0]  gdiv_ff, gdiv_in;
   logic [LEVEL_W-1:0] rsp_red_ff, rsp_green_ff;
   logic               rsp_rt_ff, rsp_valid_ff;

   logic [CFG_W:0]           goal_sum;
   logic [LEVEL_W-1:0]       goal_new;
   logic [TICK_W-1:0]        dur_full, elapsed;
   logic signed [BASE_W-1:0] base_diff, base;
   logic [DIV_W-1:0]         div_dividend, div_divisor;
   logic [CNT_W-1:0]         div_qbits;
   logic                     div_busy;
   logic [QUO_W-1:0]         div_quo;
   logic [LEVEL_W-1:0]       green_sat;

   ffcg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .qbits    (div_qbits),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   always_comb begin
      unique case (cmd.div_op)
         DIV_RECIP_T: begin
            div_dividend = DIV_W'(RECIP_NUM);
            div_divisor  = DIV_W'(time_span_ff);
            div_qbits    = Q_RECIP;
         end
         DIV_EXTRA_T: begin
            div_dividend = DIV_W'(rt_ff);
            div_divisor  = DIV_W'(recip_ff);
            div_qbits    = Q_EXTRA;
         end
         DIV_RECIP_L: begin
            div_dividend = DIV_W'(RECIP_NUM);
            div_divisor  = DIV_W'(level_span_ff);
            div_qbits    = Q_RECIP;
         end
         DIV_EXTRA_L: begin
            div_dividend = DIV_W'(rl_ff);
            div_divisor  = DIV_W'(recip_ff);
            div_qbits    = Q_EXTRA;
         end
         DIV_LEVEL: begin
            div_dividend = DIV_W'(pa_ff) + DIV_W'(pb_ff);
            div_divisor  = DIV_W'(dur_ff);
            div_qbits    = Q_LEVEL;
         end
         DIV_GREEN: begin
            div_dividend = DIV_W'(gnum_ff);
            div_divisor  = DIV_W'(gdiv_ff);
            div_qbits    = Q_GREEN;
         end
         default: begin
            div_dividend = '0;
            div_divisor  = '0;
            div_qbits    = '0;
         end
      endcase
   end

   always_comb begin
      goal_sum  = {1'b0, level_base_ff} + {1'b0, extra_l_ff};
      goal_new  = goal_sum[CFG_W] ? LEVEL_MAX : goal_sum[LEVEL_W-1:0];
      dur_full  = goal_time_ff - start_time_ff;
      dur_in    = dur_full[DUR_W-1:0];
      elapsed   = now_ff - start_time_ff;
      e_in      = (elapsed > TICK_W'(dur_in)) ? dur_in : elapsed[DUR_W-1:0];
      base_diff = $signed(BASE_W'(goal_level_ff)) - $signed(BASE_W'(start_level_ff));
      if (dur_ff == '0) begin
         base    = $signed(BASE_W'(GREEN_MUL));
         gdiv_in = GDIV_W'(GREEN_DIV);
      end else begin
         base    = $signed(BASE_W'(dur_ff) * BASE_W'(GREEN_MUL)) + (base_diff <<< 1);
         gdiv_in = GDIV_W'(dur_ff) * GDIV_W'(GREEN_DIV);
      end
      gnum_in   = base[BASE_W-1] ? '0
                : GNUM_W'(level_ff) * GNUM_W'(base[BASE_W-2:0]);
      green_sat = (|div_quo[QUO_W-1:LEVEL_W]) ? LEVEL_MAX : div_quo[LEVEL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_base_ff  <= TIME_BASE_RST;
         time_span_ff  <= TIME_SPAN_RST;
         level_base_ff <= LEVEL_BASE_RST;
         level_span_ff <= LEVEL_SPAN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TIME_BASE:  time_base_ff  <= csr_wdata;
            CSR_TIME_SPAN:  time_span_ff  <= csr_wdata;
            CSR_LEVEL_BASE: level_base_ff <= csr_wdata;
            CSR_LEVEL_SPAN: level_span_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flame_ff       <= '0;
         start_level_ff <= '0;
         goal_level_ff  <= '0;
         start_time_ff  <= '0;
         goal_time_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.commit_rt) begin
            start_level_ff <= flame_ff;
            goal_level_ff  <= goal_new;
            start_time_ff  <= now_ff;
            goal_time_ff   <= now_ff + TICK_W'(time_base_ff) + TICK_W'(extra_t_ff);
         end
         if (cmd.load_rsp && active_ff) begin
            flame_ff <= level_ff;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         active_ff   <= req_tuser;
         now_ff      <= req_tdata[31:0];
         rt_ff       <= req_tdata[63:32];
         rl_ff       <= req_tdata[95:64];
         retarget_ff <= 1'b0;
      end else if (cmd.commit_rt) begin
         retarget_ff <= 1'b1;
      end
      if (cmd.div_capture) begin
         unique case (cmd.div_op)
            DIV_RECIP_T, DIV_RECIP_L: recip_ff <= div_quo;
            DIV_EXTRA_T: extra_t_ff <= (time_span_ff == '0) ? '0 : div_quo[CFG_W-1:0];
            DIV_EXTRA_L: extra_l_ff <= (level_span_ff == '0) ? '0 : div_quo[CFG_W-1:0];
            DIV_LEVEL:   level_ff   <= div_quo[LEVEL_W-1:0];
            DIV_GREEN:   green_ff   <= green_sat;
            default: ;
         endcase
      end
      if (cmd.calc_span) begin
         dur_ff <= dur_in;
         e_ff   <= e_in;
      end
      if (cmd.calc_prod) begin
         pa_ff <= PROD_W'(start_level_ff) * PROD_W'(dur_ff - e_ff);
         pb_ff <= PROD_W'(goal_level_ff) * PROD_W'(e_ff);
         if (dur_ff == '0) begin
            level_ff <= flame_ff;
         end
      end
      if (cmd.calc_green) begin
         gnum_ff <= gnum_in;
         gdiv_ff <= gdiv_in;
      end
      if (cmd.load_rsp) begin
         rsp_red_ff   <= active_ff ? level_ff : '0;
         rsp_green_ff <= active_ff ? green_ff : '0;
         rsp_rt_ff    <= active_ff & retarget_ff;
      end
   end

   assign stat.active       = active_ff;
   assign stat.retarget_due = (goal_time_ff < now_ff);
   assign stat.dur_zero     = (dur_ff == '0);
   assign stat.div_busy     = div_busy;
   assign stat.rsp_free     = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_green_ff, rsp_red_ff};
   assign rsp_tuser  = rsp_rt_ff;

endmodule

>>> hw/rtl/ffcg_ctrl.sv
// Controller: sequences retarget, interpolation and green divisions per transaction.
`timescale 1ns / 1ps

module ffcg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  ffcg_pkg::dp_stat_type  stat,
   output ffcg_pkg::ctrl_cmd_type cmd
);
   import ffcg_pkg::*;

   ctrl_state_type state_ff, state_in;
   div_op_type     op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= DIV_RECIP_T;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      cmd        = '0;
      cmd.div_op = op_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!stat.active) begin
               state_in = ST_RESULT;
            end else if (stat.retarget_due) begin
               op_in    = DIV_RECIP_T;
               state_in = ST_DIV_GO;
            end else begin
               state_in = ST_SPAN;
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (!stat.div_busy) begin
               cmd.div_capture = 1'b1;
               unique case (op_ff)
                  DIV_RECIP_T: begin
                     op_in    = DIV_EXTRA_T;
                     state_in = ST_DIV_GO;
                  end
                  DIV_EXTRA_T: begin
                     op_in    = DIV_RECIP_L;
                     state_in = ST_DIV_GO;
                  end
                  DIV_RECIP_L: begin
                     op_in    = DIV_EXTRA_L;
                     state_in = ST_DIV_GO;
                  end
                  DIV_EXTRA_L: state_in = ST_COMMIT;
                  DIV_LEVEL:   state_in = ST_GREEN_PREP;
                  DIV_GREEN:   state_in = ST_RESULT;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_COMMIT: begin
            cmd.commit_rt = 1'b1;
            state_in      = ST_SPAN;
         end
         ST_SPAN: begin
            cmd.calc_span = 1'b1;
            state_in      = ST_PROD;
         end
         ST_PROD: begin
            cmd.calc_prod = 1'b1;
            if (stat.dur_zero) begin
               state_in = ST_GREEN_PREP;
            end else begin
               op_in    = DIV_LEVEL;
               state_in = ST_DIV_GO;
            end
         end
         ST_GREEN_PREP: begin
            cmd.calc_green = 1'b1;
            op_in          = DIV_GREEN;
            state_in       = ST_DIV_GO;
         end
         ST_RESULT: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
